/* sv/ptt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared constants and controller/datapath interface types for the periodic
// timer table.
// ----------------------------------------------------------------------------
package ptt_pkg;

   localparam int NUM_TIMERS = 64;
   localparam int MAX_FIRE   = 64;
   localparam int IDXW       = $clog2(NUM_TIMERS);
   localparam int FCW        = $clog2(MAX_FIRE + 1);
   localparam int ID_LIMIT   = (NUM_TIMERS < 64) ? NUM_TIMERS : 64;

   localparam logic [1:0] MODE_SET   = 2'd0;
   localparam logic [1:0] MODE_KILL  = 2'd1;
   localparam logic [1:0] MODE_CHECK = 2'd2;

   typedef struct packed {
      logic load;       // capture request
      logic apply;      // set / kill / time update
      logic scan_clr;   // start a table scan
      logic fire;       // re-arm or disarm earliest timer
      logic emit;       // load response register
      logic emit_fire;
      logic emit_last;
      logic emit_more;
   } ptt_cmd_type;

   typedef struct packed {
      logic is_check;
      logic scan_done;
      logic due;
      logic out_free;
   } ptt_stat_type;

endpackage
`default_nettype wire

/* sv/periodic_timer_table_top.sv */
`default_nettype none
// A set, kill or check with nothing due answers after one table scan; a check's first
// firing answers after two table scans and each further firing after one more scan.
// Flow: one request at a time, the next taken in the cycle after the last response is
// loaded; each scan reads one table entry per cycle. Output stalls delay responses.
// Reset: synchronous; clears current time, active flags, sequencer and response valid.
// ----------------------------------------------------------------------------
// periodic_timer_table_top
// Timer table with earliest-deadline firing, capped per check.
// ----------------------------------------------------------------------------
module periodic_timer_table_top
   import ptt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_mode,
   input  wire logic [5:0]  req_timer_id,
   input  wire logic [31:0] req_delay,
   input  wire logic [31:0] req_repeat_interval,
   input  wire logic [63:0] req_now,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_fired_valid,
   output logic [5:0]       rsp_fired_id,
   output logic             rsp_last,
   output logic             rsp_more_pending,
   output logic [63:0]      rsp_next_deadline
);

   ptt_cmd_type  cmd;
   ptt_stat_type stat;

   ptt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ptt_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .req_mode            (req_mode),
      .req_timer_id        (req_timer_id),
      .req_delay           (req_delay),
      .req_repeat_interval (req_repeat_interval),
      .req_now             (req_now),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_fired_valid     (rsp_fired_valid),
      .rsp_fired_id        (rsp_fired_id),
      .rsp_last            (rsp_last),
      .rsp_more_pending    (rsp_more_pending),
      .rsp_next_deadline   (rsp_next_deadline),
      .cmd                 (cmd),
      .stat                (stat)
   );

endmodule
`default_nettype wire

/* sv/ptt_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_ctrl
// Sequencer: apply request, scan table, emit responses, fire due timers.
// ----------------------------------------------------------------------------
module ptt_ctrl
   import ptt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire ptt_stat_type stat,
   output ptt_cmd_type       cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_APPLY  = 3'd1;
   localparam logic [2:0] ST_START  = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_DECIDE = 3'd4;
   localparam logic [2:0] ST_FIRE   = 3'd5;

   logic [2:0]     state_ff, state_in;
   logic [FCW-1:0] fcnt_ff, fcnt_in;
   logic           pend_ff, pend_in;

   logic cap_left;
   logic skip_emit;
   logic proceed;

   assign req_stall = (state_ff != ST_IDLE);
   assign cap_left  = (fcnt_ff < FCW'(MAX_FIRE));
   assign skip_emit = stat.is_check && !pend_ff && stat.due;
   assign proceed   = stat.out_free || skip_emit;

   always_comb begin
      state_in = state_ff;
      fcnt_in  = fcnt_ff;
      pend_in  = pend_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            fcnt_in   = '0;
            pend_in   = 1'b0;
            state_in  = ST_START;
         end
         ST_START: begin
            cmd.scan_clr = 1'b1;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            if (stat.scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (proceed) begin
               cmd.emit = !skip_emit;
               if (stat.is_check && pend_ff) begin
                  cmd.emit_fire = 1'b1;
                  cmd.emit_last = !(stat.due && cap_left);
                  cmd.emit_more = stat.due && !cap_left;
               end else begin
                  cmd.emit_last = 1'b1;
               end
               if (stat.is_check && stat.due && cap_left) begin
                  state_in = ST_FIRE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FIRE: begin
            cmd.fire = 1'b1;
            fcnt_in  = fcnt_ff + FCW'(1);
            pend_in  = 1'b1;
            state_in = ST_START;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fcnt_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fcnt_ff  <= fcnt_in;
         pend_ff  <= pend_in;
      end
   end

endmodule
`default_nettype wire

/* sv/ptt_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_datapath
// Timer tables, sequential minimum-deadline scan, saturating adders and the
// response register.
// ----------------------------------------------------------------------------
module ptt_datapath
   import ptt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [1:0]  req_mode,
   input  wire logic [5:0]  req_timer_id,
   input  wire logic [31:0] req_delay,
   input  wire logic [31:0] req_repeat_interval,
   input  wire logic [63:0] req_now,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_fired_valid,
   output logic [5:0]       rsp_fired_id,
   output logic             rsp_last,
   output logic             rsp_more_pending,
   output logic [63:0]      rsp_next_deadline,
   input  wire ptt_cmd_type cmd,
   output ptt_stat_type     stat
);

   logic [63:0] dl_mem [NUM_TIMERS];
   logic [31:0] pd_mem [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] act_ff;

   logic [1:0]  mode_ff;
   logic [5:0]  id_ff;
   logic [31:0] delay_ff, intv_ff;
   logic [63:0] now_ff;
   logic [63:0] cur_time_ff;

   logic [IDXW-1:0] idx_ff, cmp_idx_ff;
   logic            busy_ff, cmp_vld_ff;
   logic [63:0]     rd_dl_ff;
   logic [31:0]     rd_pd_ff;

   logic            best_found_ff;
   logic [63:0]     best_dl_ff;
   logic [31:0]     best_pd_ff;
   logic [IDXW-1:0] best_id_ff;
   logic [IDXW-1:0] fire_id_ff;

   logic            rsp_valid_ff, rsp_fire_ff, rsp_last_ff, rsp_more_ff;
   logic [5:0]      rsp_id_ff;
   logic [63:0]     rsp_dl_ff;

   logic            id_ok;
   logic [IDXW-1:0] req_addr;
   logic [64:0]     set_sum, fire_sum;
   logic [63:0]     set_dl, fire_dl;
   logic            better;
   logic            out_free;

   assign id_ok    = (32'(id_ff) < ID_LIMIT);
   assign req_addr = IDXW'(id_ff);
   assign set_sum  = {1'b0, cur_time_ff} + {33'd0, delay_ff};
   assign set_dl   = set_sum[64] ? '1 : set_sum[63:0];
   assign fire_sum = {1'b0, best_dl_ff} + {33'd0, best_pd_ff};
   assign fire_dl  = fire_sum[64] ? '1 : fire_sum[63:0];
   assign better   = cmp_vld_ff && act_ff[cmp_idx_ff] &&
                     (!best_found_ff || (rd_dl_ff < best_dl_ff));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      stat.is_check  = (mode_ff == MODE_CHECK);
      stat.scan_done = cmp_vld_ff && (cmp_idx_ff == IDXW'(NUM_TIMERS - 1));
      stat.due       = best_found_ff && (best_dl_ff <= cur_time_ff);
      stat.out_free  = out_free;
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_mode;
         id_ff    <= req_timer_id;
         delay_ff <= req_delay;
         intv_ff  <= req_repeat_interval;
         now_ff   <= req_now;
      end
   end

   // tables
   always_ff @(posedge clock) begin
      if (cmd.apply && mode_ff == MODE_SET && id_ok) begin
         dl_mem[req_addr] <= set_dl;
      end else if (cmd.fire && best_pd_ff != 32'd0) begin
         dl_mem[best_id_ff] <= fire_dl;
      end
      if (cmd.apply && mode_ff == MODE_SET && id_ok) begin
         pd_mem[req_addr] <= intv_ff;
      end
      rd_dl_ff <= dl_mem[idx_ff];
      rd_pd_ff <= pd_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff      <= '0;
         cur_time_ff <= '0;
      end else begin
         if (cmd.apply) begin
            if (mode_ff == MODE_CHECK) begin
               cur_time_ff <= now_ff;
            end else if (id_ok && mode_ff == MODE_SET) begin
               act_ff[req_addr] <= 1'b1;
            end else if (id_ok && mode_ff == MODE_KILL) begin
               act_ff[req_addr] <= 1'b0;
            end
         end
         if (cmd.fire && best_pd_ff == 32'd0) begin
            act_ff[best_id_ff] <= 1'b0;
         end
      end
   end

   // scan
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         cmp_vld_ff <= 1'b0;
         idx_ff     <= '0;
      end else if (cmd.scan_clr) begin
         busy_ff    <= 1'b1;
         cmp_vld_ff <= 1'b0;
         idx_ff     <= '0;
      end else begin
         cmp_vld_ff <= busy_ff;
         if (busy_ff) begin
            if (idx_ff == IDXW'(NUM_TIMERS - 1)) begin
               busy_ff <= 1'b0;
            end else begin
               idx_ff <= idx_ff + IDXW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= idx_ff;
      if (cmd.scan_clr) begin
         best_found_ff <= 1'b0;
      end else if (better) begin
         best_found_ff <= 1'b1;
         best_dl_ff    <= rd_dl_ff;
         best_pd_ff    <= rd_pd_ff;
         best_id_ff    <= cmp_idx_ff;
      end
      if (cmd.fire) begin
         fire_id_ff <= best_id_ff;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_fire_ff <= cmd.emit_fire;
         rsp_id_ff   <= cmd.emit_fire ? 6'(fire_id_ff) : 6'd0;
         rsp_last_ff <= cmd.emit_last;
         rsp_more_ff <= cmd.emit_more;
         rsp_dl_ff   <= best_found_ff ? best_dl_ff : 64'd0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fired_valid   = rsp_fire_ff;
   assign rsp_fired_id      = rsp_id_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_more_pending  = rsp_more_ff;
   assign rsp_next_deadline = rsp_dl_ff;

endmodule
`default_nettype wire
